>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the running statistics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle check failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

>>> rtl/core/rmsw_pkg.sv
// Package of the running mean and deviation block: sizes, codes and types
package rmsw_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 20;
   localparam int FRAC_BITS_DEF   = 8;

   // fixed field widths
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int MEAN_W      = 24;
   localparam int DEV_W       = 24;
   localparam int WIN_W       = 25;
   localparam int COUNT_OUT_W = 21;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_MINIMUM = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_MAXIMUM = 1'b1;

   localparam logic signed [CSR_DATA_W-1:0] DATA_MINIMUM_RESET = 16'sh8000;
   localparam logic signed [CSR_DATA_W-1:0] DATA_MAXIMUM_RESET = 16'sh7FFF;

   // item codes
   localparam logic OP_CLEAR  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_LOAD,
      ST_MULTIPLY,
      ST_MEAN,
      ST_ROOT,
      ST_DEVIATE,
      ST_DONE
   } rmsw_state_type;

   // status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } rmsw_unit_stat_type;

endpackage

>>> rtl/core/running_mean_stddev_window.sv
// Top level of the running mean, standard deviation and display window block
//
// Each transfer on the req_ channel is either a clear (req_op = 0) or a signed
// sample (req_op = 1), and each gives exactly one transfer on the rsp_ channel.
// A sample adds to a running sum, a sum of squares and a count, then the block
// reports the mean (rounded toward minus infinity), the population standard
// deviation (rounded down) and the window mean -/+ deviation, all with
// FRAC_BITS fraction bits. The variance numerator n*Q - S*S is exact; the
// deviation is floor(isqrt((n*Q - S*S) << 2*FRAC_BITS) / n). Once the count
// reaches 2^COUNT_BITS further samples leave the statistics alone and come
// back with rsp_saturated set. A clear zeroes the accumulators and reports the
// data_minimum and data_maximum registers, scaled, as the window. All the
// arithmetic is bit-serial: the squaring and both products run one bit per
// cycle, one restoring divider runs twice (mean, then deviation) and the square
// root yields one bit per cycle. A sample passes through the square (skipped
// when saturated), load, multiply, mean, root, deviate and done states in
// turn; a clear goes from idle straight to the done state. From done the
// result is loaded into the output register once it is empty or being taken.
// A new item is taken once the previous result sits in the output register,
// which holds it until the rsp_ transfer. csr_ writes are always taken and
// must come only while the block is idle.
`include "assert_macros.svh"

module running_mean_stddev_window
   import rmsw_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [MEAN_W-1:0]      rsp_mean_fixed,
   output logic [DEV_W-1:0]              rsp_deviation_fixed,
   output logic signed [WIN_W-1:0]       rsp_window_low,
   output logic signed [WIN_W-1:0]       rsp_window_high,
   output logic [COUNT_OUT_W-1:0]        rsp_sample_count,
   output logic                          rsp_saturated,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int CW     = COUNT_BITS + 1;                 // count, holds 2^COUNT_BITS
   localparam int SUMW   = SAMPLE_BITS + COUNT_BITS + 1;   // signed sum
   localparam int MAGW   = SAMPLE_BITS + COUNT_BITS;       // |sum|
   localparam int SQW    = 2 * SAMPLE_BITS - 1 + COUNT_BITS; // sum of squares
   localparam int PW     = 2 * (SAMPLE_BITS + COUNT_BITS); // n*Q and S*S
   localparam int NUMW   = SAMPLE_BITS + COUNT_BITS + FRAC_BITS; // dividend, root
   localparam int XW     = 2 * NUMW;                       // radicand
   localparam int MW     = NUMW + 1;                       // signed mean
   localparam int STEP_W = $clog2(MAGW);

   localparam logic [CW-1:0] COUNT_MAX = {1'b1, {COUNT_BITS{1'b0}}};

   rmsw_state_type state_ff, state_in;

   // accumulators
   logic signed [SUMW-1:0] sum_ff;
   logic [SQW-1:0]         sqsum_ff;
   logic [CW-1:0]          count_ff;

   // registers
   logic signed [CSR_DATA_W-1:0] csr_min_ff;
   logic signed [CSR_DATA_W-1:0] csr_max_ff;

   // shift-add products
   logic [PW-1:0]     nq_mcand_ff;
   logic [CW-1:0]     nq_mplier_ff;
   logic [PW-1:0]     nq_acc_ff;
   logic [PW-1:0]     ss_mcand_ff;
   logic [MAGW-1:0]   ss_mplier_ff;
   logic [PW-1:0]     ss_acc_ff;
   logic [STEP_W-1:0] step_ff;

   // per-item results
   logic                 clear_ff;
   logic                 sat_ff;
   logic                 neg_ff;
   logic signed [MW-1:0] mean_ff, mean_in;
   logic [NUMW-1:0]      dev_ff;

   // output register
   logic                          rsp_valid_ff;
   logic signed [MEAN_W-1:0]      rsp_mean_ff;
   logic [DEV_W-1:0]              rsp_dev_ff;
   logic signed [WIN_W-1:0]       rsp_low_ff, win_low_in;
   logic signed [WIN_W-1:0]       rsp_high_ff, win_high_in;
   logic [COUNT_OUT_W-1:0]        rsp_count_ff;
   logic                          rsp_sat_ff;

   // arithmetic units
   logic               div_start;
   logic [NUMW-1:0]    div_num;
   logic [NUMW-1:0]    div_quotient;
   logic               div_rem_nz;
   rmsw_unit_stat_type div_stat;
   logic               root_start;
   logic [XW-1:0]      root_rad;
   logic [NUMW-1:0]    root_value;
   rmsw_unit_stat_type root_stat;

   logic                   out_load;
   logic                   count_full;
   logic [SAMPLE_BITS-1:0] sample_abs;
   logic signed [SUMW-1:0] sum_neg;
   logic [MAGW-1:0]        sum_mag;
   logic [NUMW-1:0]        mean_num;
   logic [MW-1:0]          mean_pos;
   logic [MW-1:0]          mean_adj;

   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign count_full = (count_ff == COUNT_MAX);

   // ---------------------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------------------
   always_comb begin
      sample_abs = req_sample_value[SAMPLE_BITS-1] ? SAMPLE_BITS'(-req_sample_value)
                                                   : req_sample_value;
      sum_neg    = -sum_ff;
      sum_mag    = sum_ff[SUMW-1] ? sum_neg[MAGW-1:0] : sum_ff[MAGW-1:0];
      mean_num   = NUMW'(sum_mag) << FRAC_BITS;

      // negative mean rounds toward minus infinity: -(q + any remainder)
      mean_pos   = {1'b0, div_quotient};
      mean_adj   = mean_pos + MW'(div_rem_nz);
      mean_in    = neg_ff ? $signed(MW'(-mean_adj)) : $signed(mean_pos);

      // n*Q >= S*S always holds for exact sums; zero kept as a guard
      root_rad   = (nq_acc_ff >= ss_acc_ff) ?
                   (XW'(nq_acc_ff - ss_acc_ff) << (2 * FRAC_BITS)) : '0;

      // window wraps at 25 bits like the field itself
      if (clear_ff) begin
         win_low_in  = WIN_W'(csr_min_ff) << FRAC_BITS;
         win_high_in = WIN_W'(csr_max_ff) << FRAC_BITS;
      end else begin
         win_low_in  = WIN_W'(mean_ff) - WIN_W'(dev_ff);
         win_high_in = WIN_W'(mean_ff) + WIN_W'(dev_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_start  = 1'b0;
      root_start = 1'b0;
      out_load   = 1'b0;
      div_num    = (state_ff == ST_LOAD) ? mean_num : root_value;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_CLEAR) begin
                  state_in = ST_DONE;
               end else if (count_full) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            if (step_ff == '0) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            if (step_ff == '0) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (div_stat.done) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_stat.done) begin
               div_start = 1'b1;
               state_in  = ST_DEVIATE;
            end
         end
         ST_DEVIATE: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Accumulators and registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         sqsum_ff <= '0;
         count_ff <= '0;
      end else if (req_valid && req_ready) begin
         if (req_op == OP_CLEAR) begin
            sum_ff   <= '0;
            sqsum_ff <= '0;
            count_ff <= '0;
         end else if (!count_full) begin
            sum_ff   <= sum_ff + SUMW'(req_sample_value);
            count_ff <= count_ff + 1'b1;
         end
      end else if (state_ff == ST_SQUARE && ss_mplier_ff[0]) begin
         // sample squared one multiplier bit per cycle straight into Q
         sqsum_ff <= sqsum_ff + SQW'(ss_mcand_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_min_ff <= DATA_MINIMUM_RESET;
         csr_max_ff <= DATA_MAXIMUM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DATA_MINIMUM: csr_min_ff <= csr_data;
            CSR_DATA_MAXIMUM: csr_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Serial products and per-item results
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               clear_ff     <= (req_op == OP_CLEAR);
               sat_ff       <= (req_op == OP_SAMPLE) && count_full;
               mean_ff      <= '0;
               dev_ff       <= '0;
               ss_mcand_ff  <= PW'(sample_abs);
               ss_mplier_ff <= MAGW'(sample_abs);
               step_ff      <= STEP_W'(SAMPLE_BITS - 1);
            end
         end
         ST_SQUARE: begin
            ss_mcand_ff  <= ss_mcand_ff << 1;
            ss_mplier_ff <= ss_mplier_ff >> 1;
            step_ff      <= step_ff - 1'b1;
         end
         ST_LOAD: begin
            nq_mcand_ff  <= PW'(sqsum_ff);
            nq_mplier_ff <= count_ff;
            nq_acc_ff    <= '0;
            ss_mcand_ff  <= PW'(sum_mag);
            ss_mplier_ff <= sum_mag;
            ss_acc_ff    <= '0;
            neg_ff       <= sum_ff[SUMW-1];
            step_ff      <= STEP_W'(MAGW - 1);
         end
         ST_MULTIPLY: begin
            // n*Q and S*S side by side; n runs out of bits first
            if (nq_mplier_ff[0]) begin
               nq_acc_ff <= nq_acc_ff + nq_mcand_ff;
            end
            if (ss_mplier_ff[0]) begin
               ss_acc_ff <= ss_acc_ff + ss_mcand_ff;
            end
            nq_mcand_ff  <= nq_mcand_ff << 1;
            nq_mplier_ff <= nq_mplier_ff >> 1;
            ss_mcand_ff  <= ss_mcand_ff << 1;
            ss_mplier_ff <= ss_mplier_ff >> 1;
            step_ff      <= step_ff - 1'b1;
         end
         ST_MEAN: begin
            if (div_stat.done) begin
               mean_ff <= mean_in;
            end
         end
         ST_DEVIATE: begin
            if (div_stat.done) begin
               dev_ff <= div_quotient;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_mean_ff  <= MEAN_W'(mean_ff);
         rsp_dev_ff   <= DEV_W'(dev_ff);
         rsp_low_ff   <= win_low_in;
         rsp_high_ff  <= win_high_in;
         rsp_count_ff <= COUNT_OUT_W'(count_ff);
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mean_fixed      = rsp_mean_ff;
   assign rsp_deviation_fixed = rsp_dev_ff;
   assign rsp_window_low      = rsp_low_ff;
   assign rsp_window_high     = rsp_high_ff;
   assign rsp_sample_count    = rsp_count_ff;
   assign rsp_saturated       = rsp_sat_ff;

   // ---------------------------------------------------------------------------
   // Arithmetic units
   // ---------------------------------------------------------------------------
   rmsw_serial_div #(
      .NUM_BITS (NUMW),
      .DEN_BITS (CW)
   ) u_div (
      .clock             (clock),
      .reset             (reset),
      .start             (div_start),
      .numerator         (div_num),
      .denominator       (count_ff),
      .quotient          (div_quotient),
      .remainder_nonzero (div_rem_nz),
      .stat              (div_stat)
   );

   rmsw_serial_sqrt #(
      .ROOT_BITS (NUMW)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_rad),
      .root     (root_value),
      .stat     (root_stat)
   );

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLY(a_sat_at_full_count, clock, reset, rsp_valid_ff && rsp_sat_ff, rsp_count_ff == COUNT_OUT_W'(COUNT_MAX))
   `ASSERT_IMPLY(a_units_idle_at_done, clock, reset, state_ff == ST_DONE, !div_stat.busy && !root_stat.busy)
   `ASSERT_IMPLY(a_root_ready_for_divide, clock, reset, state_ff == ST_DEVIATE, root_stat.done)
   `ASSERT_IMPLY(a_rsp_only_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE))

endmodule

>>> rtl/core/rmsw_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle
module rmsw_serial_div
   import rmsw_pkg::*;
#(
   parameter int NUM_BITS = SAMPLE_BITS_DEF + COUNT_BITS_DEF + FRAC_BITS_DEF,
   parameter int DEN_BITS = COUNT_BITS_DEF + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numerator,
   input  logic [DEN_BITS-1:0] denominator,
   output logic [NUM_BITS-1:0] quotient,
   output logic                remainder_nonzero,
   output rmsw_unit_stat_type  stat
);

   localparam int STEP_W = $clog2(NUM_BITS);

   logic [NUM_BITS-1:0] work_ff, work_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [DEN_BITS:0]   rem_shift;
   logic [DEN_BITS:0]   rem_diff;
   logic                fits;

   always_comb begin
      rem_shift = {rem_ff, work_ff[NUM_BITS-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = fits ? rem_diff[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
      work_in   = {work_ff[NUM_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && step_ff == '0) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   // numerator shifts out at the top while quotient bits enter at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= numerator;
         rem_ff  <= '0;
         den_ff  <= denominator;
         step_ff <= STEP_W'(NUM_BITS - 1);
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff - 1'b1;
      end
   end

   assign quotient          = work_ff;
   assign remainder_nonzero = |rem_ff;
   assign stat.busy         = busy_ff;
   assign stat.done         = done_ff;

endmodule

>>> rtl/core/rmsw_serial_sqrt.sv
// Digit-serial integer square root: two radicand bits and one root bit per cycle
module rmsw_serial_sqrt
   import rmsw_pkg::*;
#(
   parameter int ROOT_BITS = SAMPLE_BITS_DEF + COUNT_BITS_DEF + FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2*ROOT_BITS-1:0] radicand,
   output logic [ROOT_BITS-1:0]   root,
   output rmsw_unit_stat_type     stat
);

   localparam int STEP_W = $clog2(ROOT_BITS);

   logic [2*ROOT_BITS-1:0] rad_ff;
   logic [ROOT_BITS+1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [STEP_W-1:0]      step_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [ROOT_BITS+1:0]   rem_shift;
   logic [ROOT_BITS+1:0]   trial;
   logic                   fits;

   // remainder never exceeds 2*root, so its top two bits are free before the shift
   always_comb begin
      rem_shift = {rem_ff[ROOT_BITS-1:0], rad_ff[2*ROOT_BITS-1 -: 2]};
      trial     = {root_ff, 2'b01};
      fits      = rem_shift >= trial;
      rem_in    = fits ? rem_shift - trial : rem_shift;
      root_in   = {root_ff[ROOT_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && step_ff == '0) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= STEP_W'(ROOT_BITS - 1);
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         step_ff <= step_ff - 1'b1;
      end
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
